// ===== src/sps_pkg.sv =====
// sps_pkg: shared widths, lane/item types and the divider step for the
// segment pair separation block. No dependencies.
`default_nettype none
package sps_pkg;

    localparam int CW     = 16;          // coordinate width
    localparam int DW     = CW + 1;      // difference width
    localparam int PW     = 2 * DW;      // product width
    localparam int TB     = 16;          // fraction bits of the projection
    localparam int SW     = PW + 1 - TB; // displacement width
    localparam int LW     = 2 * SW + 1;  // squared length width
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_START = 2'd0; // closest point is the segment start
    localparam t_mode MODE_END   = 2'd1; // closest point is the segment end
    localparam t_mode MODE_FRAC  = 2'd2; // closest point is inside the segment

    typedef struct packed {
        t_mode                 mode;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic signed [DW-1:0]  rx;
        logic signed [DW-1:0]  ry;
        logic        [PW-1:0]  rem;
        logic        [PW-1:0]  den;
        logic        [TB-1:0]  q;
    } t_lane;

    typedef struct packed {
        logic            crossing;
        t_lane [3:0]     lane;
    } t_item;

    // one restoring division step: one quotient bit
    function automatic t_lane div_step(input t_lane a);
        logic [PW:0] r2;
        t_lane       b;
        begin
            b  = a;
            r2 = {a.rem, 1'b0};
            if (r2 >= {1'b0, a.den}) begin
                b.rem = PW'(r2 - {1'b0, a.den});
                b.q   = {a.q[TB-2:0], 1'b1};
            end else begin
                b.rem = r2[PW-1:0];
                b.q   = {a.q[TB-2:0], 1'b0};
            end
            return b;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/sps_if.sv =====
// sps_if: valid/ready channel interfaces for query and result transactions.
// Depends on sps_pkg.
`default_nettype none
interface sps_in_if import sps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] seg_a_start_x;
    logic signed [CW-1:0] seg_a_start_y;
    logic signed [CW-1:0] seg_a_end_x;
    logic signed [CW-1:0] seg_a_end_y;
    logic signed [CW-1:0] seg_b_start_x;
    logic signed [CW-1:0] seg_b_start_y;
    logic signed [CW-1:0] seg_b_end_x;
    logic signed [CW-1:0] seg_b_end_y;

    modport source (output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                    seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, input ready);
    modport sink   (input valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                    seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, output ready);
endinterface

interface sps_out_if import sps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 crossing;
    logic signed [DW-1:0] sep_x;
    logic signed [DW-1:0] sep_y;

    modport source (output valid, crossing, sep_x, sep_y, input ready);
    modport sink   (input valid, crossing, sep_x, sep_y, output ready);
endinterface
`default_nettype wire

// ===== src/sps_front.sv =====
// sps_front: accepts queries, forms differences, dot products and orientation
// terms, and classifies each of the four projections. Depends on sps_pkg, sps_if.
`default_nettype none
module sps_front import sps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sps_in_if.sink    i_seg,
    input  wire logic i_full,
    output logic      o_push,
    output t_item     o_item
);

    logic w_en;
    logic r_v1, r_v2, r_v3;

    // stage 1: differences
    logic signed [DW-1:0] r_dax, r_day, r_dbx, r_dby;
    logic signed [DW-1:0] r_rx [4];
    logic signed [DW-1:0] r_ry [4];
    logic signed [DW-1:0] r_ex [4];
    logic signed [DW-1:0] r_ey [4];

    // stage 2: products
    logic signed [DW-1:0] r_dax2, r_day2, r_dbx2, r_dby2;
    logic signed [DW-1:0] r_rx2 [4];
    logic signed [DW-1:0] r_ry2 [4];
    logic signed [PW-1:0] r_pnx [4];
    logic signed [PW-1:0] r_pny [4];
    logic signed [PW-1:0] r_ox1 [4];
    logic signed [PW-1:0] r_ox2 [4];
    logic signed [PW-1:0] r_daa, r_dab, r_dba, r_dbb;

    // stage 3 combinational
    logic signed [PW:0]   w_num [4];
    logic        [PW:0]   w_den [4];
    logic signed [PW:0]   w_ov  [4];
    logic        [1:0]    w_oc  [4];
    t_item                w_item;

    function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    assign w_en        = !r_v3 || !i_full;
    assign i_seg.ready = w_en;
    assign o_push      = r_v3 && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_seg.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dax <= dif(i_seg.seg_a_end_x, i_seg.seg_a_start_x);
            r_day <= dif(i_seg.seg_a_end_y, i_seg.seg_a_start_y);
            r_dbx <= dif(i_seg.seg_b_end_x, i_seg.seg_b_start_x);
            r_dby <= dif(i_seg.seg_b_end_y, i_seg.seg_b_start_y);
            // lanes: A start onto B, A end onto B, B start onto A, B end onto A
            r_rx[0] <= dif(i_seg.seg_a_start_x, i_seg.seg_b_start_x);
            r_ry[0] <= dif(i_seg.seg_a_start_y, i_seg.seg_b_start_y);
            r_rx[1] <= dif(i_seg.seg_a_end_x,   i_seg.seg_b_start_x);
            r_ry[1] <= dif(i_seg.seg_a_end_y,   i_seg.seg_b_start_y);
            r_rx[2] <= dif(i_seg.seg_b_start_x, i_seg.seg_a_start_x);
            r_ry[2] <= dif(i_seg.seg_b_start_y, i_seg.seg_a_start_y);
            r_rx[3] <= dif(i_seg.seg_b_end_x,   i_seg.seg_a_start_x);
            r_ry[3] <= dif(i_seg.seg_b_end_y,   i_seg.seg_a_start_y);
            // orientation: third point minus segment end
            r_ex[0] <= dif(i_seg.seg_b_start_x, i_seg.seg_a_end_x);
            r_ey[0] <= dif(i_seg.seg_b_start_y, i_seg.seg_a_end_y);
            r_ex[1] <= dif(i_seg.seg_b_end_x,   i_seg.seg_a_end_x);
            r_ey[1] <= dif(i_seg.seg_b_end_y,   i_seg.seg_a_end_y);
            r_ex[2] <= dif(i_seg.seg_a_start_x, i_seg.seg_b_end_x);
            r_ey[2] <= dif(i_seg.seg_a_start_y, i_seg.seg_b_end_y);
            r_ex[3] <= dif(i_seg.seg_a_end_x,   i_seg.seg_b_end_x);
            r_ey[3] <= dif(i_seg.seg_a_end_y,   i_seg.seg_b_end_y);

            r_dax2 <= r_dax;
            r_day2 <= r_day;
            r_dbx2 <= r_dbx;
            r_dby2 <= r_dby;
            r_daa  <= r_dax * r_dax;
            r_dab  <= r_day * r_day;
            r_dba  <= r_dbx * r_dbx;
            r_dbb  <= r_dby * r_dby;
            for (int l = 0; l < 4; l++) begin
                r_rx2[l] <= r_rx[l];
                r_ry2[l] <= r_ry[l];
                r_pnx[l] <= r_rx[l] * ((l < 2) ? r_dbx : r_dax);
                r_pny[l] <= r_ry[l] * ((l < 2) ? r_dby : r_day);
                r_ox1[l] <= ((l < 2) ? r_day : r_dby) * r_ex[l];
                r_ox2[l] <= ((l < 2) ? r_dax : r_dbx) * r_ey[l];
            end

            o_item <= w_item;
        end
    end

    always_comb begin
        w_item.crossing = 1'b0;
        for (int l = 0; l < 4; l++) begin
            w_num[l] = (PW+1)'(r_pnx[l]) + (PW+1)'(r_pny[l]);
            w_den[l] = (l < 2) ? ((PW+1)'($unsigned(r_dba)) + (PW+1)'($unsigned(r_dbb)))
                               : ((PW+1)'($unsigned(r_daa)) + (PW+1)'($unsigned(r_dab)));
            w_ov[l]  = (PW+1)'(r_ox1[l]) - (PW+1)'(r_ox2[l]);
            w_oc[l]  = {w_ov[l] == '0, w_ov[l][PW]};

            w_item.lane[l].dx  = (l < 2) ? r_dbx2 : r_dax2;
            w_item.lane[l].dy  = (l < 2) ? r_dby2 : r_day2;
            w_item.lane[l].rx  = r_rx2[l];
            w_item.lane[l].ry  = r_ry2[l];
            w_item.lane[l].rem = w_num[l][PW-1:0];
            w_item.lane[l].den = w_den[l][PW-1:0];
            w_item.lane[l].q   = '0;
            if (w_den[l] == '0 || w_num[l][PW]) begin
                w_item.lane[l].mode = MODE_START;
            end else if ($unsigned(w_num[l]) >= w_den[l]) begin
                w_item.lane[l].mode = MODE_END;
            end else begin
                w_item.lane[l].mode = MODE_FRAC;
            end
        end
        w_item.crossing = (w_oc[0] != w_oc[1]) && (w_oc[2] != w_oc[3]);
    end

endmodule
`default_nettype wire

// ===== src/sps_fifo.sv =====
// sps_fifo: short queue of classified transactions between front and back.
// Depends on sps_pkg.
`default_nettype none
module sps_fifo import sps_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_data
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_full  = r_cnt == (QAW+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// ===== src/sps_back.sv =====
// sps_back: pipelined projection divider, closest point, squared lengths and
// shortest displacement selection. Depends on sps_pkg, sps_if.
`default_nettype none
module sps_back import sps_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_avail,
    input  wire t_item i_item,
    output logic       o_pop,
    sps_out_if.source  o_sep
);

    logic w_en;

    t_item               r_d [TB+1];
    logic [TB:0]         r_dv;

    t_item               r_mi;
    logic                r_mv;
    logic signed [PW-1:0] r_px [4];
    logic signed [PW-1:0] r_py [4];

    logic                r_rv, r_rc;
    logic signed [SW-1:0] r_sx [4];
    logic signed [SW-1:0] r_sy [4];
    logic signed [SW-1:0] w_sx [4];
    logic signed [SW-1:0] w_sy [4];
    logic signed [PW:0]   w_tx [4];
    logic signed [PW:0]   w_ty [4];

    logic                r_lv, r_lc;
    logic signed [SW-1:0] r_lx [4];
    logic signed [SW-1:0] r_ly [4];
    logic        [LW-1:0] r_len [4];

    logic                r_cv, r_cc;
    logic signed [SW-1:0] r_cx [2];
    logic signed [SW-1:0] r_cy [2];
    logic        [LW-1:0] r_clen [2];

    logic                r_ov, r_oc;
    logic signed [DW-1:0] r_ox, r_oy;

    assign w_en  = !r_ov || o_sep.ready;
    assign o_pop = w_en && i_avail;

    assign o_sep.valid    = r_ov;
    assign o_sep.crossing = r_oc;
    assign o_sep.sep_x    = r_ox;
    assign o_sep.sep_y    = r_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_mv <= 1'b0;
            r_rv <= 1'b0;
            r_lv <= 1'b0;
            r_cv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_dv <= {r_dv[TB-1:0], i_avail};
            r_mv <= r_dv[TB];
            r_rv <= r_mv;
            r_lv <= r_rv;
            r_cv <= r_lv;
            r_ov <= r_cv;
        end
    end

    // closest point: for MODE_FRAC round dx*t to nearest, ties up, then endpoint minus it
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_tx[l] = ((PW+1)'(r_px[l]) + (PW+1)'(1 << (TB-1))) >>> TB;
            w_ty[l] = ((PW+1)'(r_py[l]) + (PW+1)'(1 << (TB-1))) >>> TB;
            unique case (r_mi.lane[l].mode)
                MODE_FRAC: begin
                    w_sx[l] = SW'(r_mi.lane[l].rx) - SW'(w_tx[l]);
                    w_sy[l] = SW'(r_mi.lane[l].ry) - SW'(w_ty[l]);
                end
                MODE_END: begin
                    w_sx[l] = SW'(r_mi.lane[l].rx) - SW'(r_mi.lane[l].dx);
                    w_sy[l] = SW'(r_mi.lane[l].ry) - SW'(r_mi.lane[l].dy);
                end
                default: begin
                    w_sx[l] = SW'(r_mi.lane[l].rx);
                    w_sy[l] = SW'(r_mi.lane[l].ry);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= i_item;
            for (int k = 0; k < TB; k++) begin
                r_d[k+1].crossing <= r_d[k].crossing;
                for (int l = 0; l < 4; l++) begin
                    r_d[k+1].lane[l] <= div_step(r_d[k].lane[l]);
                end
            end

            r_mi <= r_d[TB];
            for (int l = 0; l < 4; l++) begin
                r_px[l] <= r_d[TB].lane[l].dx * $signed({1'b0, r_d[TB].lane[l].q});
                r_py[l] <= r_d[TB].lane[l].dy * $signed({1'b0, r_d[TB].lane[l].q});
            end

            r_rc <= r_mi.crossing;
            for (int l = 0; l < 4; l++) begin
                r_sx[l] <= w_sx[l];
                r_sy[l] <= w_sy[l];
            end

            // squares at full length width
            r_lc <= r_rc;
            for (int l = 0; l < 4; l++) begin
                r_lx[l]  <= r_sx[l];
                r_ly[l]  <= r_sy[l];
                r_len[l] <= $unsigned(LW'(r_sx[l]) * LW'(r_sx[l]))
                          + $unsigned(LW'(r_sy[l]) * LW'(r_sy[l]));
            end

            // earlier candidate wins ties
            r_cc <= r_lc;
            for (int p = 0; p < 2; p++) begin
                if (r_len[2*p+1] < r_len[2*p]) begin
                    r_cx[p]   <= r_lx[2*p+1];
                    r_cy[p]   <= r_ly[2*p+1];
                    r_clen[p] <= r_len[2*p+1];
                end else begin
                    r_cx[p]   <= r_lx[2*p];
                    r_cy[p]   <= r_ly[2*p];
                    r_clen[p] <= r_len[2*p];
                end
            end

            r_oc <= r_cc;
            if (r_clen[1] < r_clen[0]) begin
                r_ox <= r_cx[1][DW-1:0];
                r_oy <= r_cy[1][DW-1:0];
            end else begin
                r_ox <= r_cx[0][DW-1:0];
                r_oy <= r_cy[0][DW-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/segment_pair_separation.sv =====
// segment_pair_separation: top level; front classifier, queue, back pipeline.
// Depends on sps_pkg, sps_if, sps_front, sps_fifo, sps_back.
//
//  channel  | dir | transaction
//  ---------+-----+-----------------------------------------------------
//  i_seg    | in  | two segments, eight signed Q12.4 coordinates
//  o_sep    | out | crossing flag and shortest displacement (17 bit x, y)
//
// One transaction per cycle sustained while o_sep is ready. Path: 3 front
// stages, the queue, an input register, 16 divider steps (one quotient bit per
// stage) and 5 more. Reset is synchronous and clears only valid flags and queue
// pointers. A stall on o_sep holds the back pipeline; the front keeps accepting
// until the 4-entry queue fills.
`default_nettype none
module segment_pair_separation import sps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sps_in_if.sink    i_seg,
    sps_out_if.source o_sep
);

    logic  w_push, w_pop, w_full, w_empty;
    t_item w_fin, w_fout;

    sps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_fin)
    );

    sps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fin),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_fout)
    );

    sps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!w_empty),
        .i_item  (w_fout),
        .o_pop   (w_pop),
        .o_sep   (o_sep)
    );

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("queue popped while empty");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> i_seg.ready) else $error("front stalled with queue room");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_sep.valid) else $error("result valid after reset");

endmodule
`default_nettype wire
